// ===== rtl/cri_pkg.sv =====
// Shared constants for the Catmull-Rom path interpolator.
// No dependencies; used by the top level, cri_front and cri_back.
package cri_pkg;
	localparam int DEF_MAX_SAMPLES = 31;
	localparam int DEF_COORD_BITS = 32;
	localparam int COUNT_BITS = 5;
	localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RESET = 5'd20;
	localparam int FRAC_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	// extra bits so 2*p0 - 5*p1 + 4*p2 - p3 cannot overflow
	localparam int COEF_GUARD = 4;
endpackage

// ===== rtl/catmull_rom_path_interpolator.sv =====
// Uniform Catmull-Rom path interpolator, top level.
// Holds the sample count register and joins front, job queue and back.
// Depends on cri_pkg, cri_front, cri_fifo, cri_back.
//
// Usage: control points enter on point_x/point_y/path_end with in_valid and
// in_ready; samples leave on sample_x/sample_y/final_sample with out_valid and
// out_ready. cfg_we writes cfg_wdata into sample_count (reset 20); the user must
// assert cfg_we only while idle, which the block does not enforce. Each point
// but the last yields one segment of n samples once the two points after it, or
// a next point that ends the path, are known; a path_end point yields the
// pending segments and then the point itself with final_sample set. The front
// takes a new point only when idle, after pushing the last one's jobs, at most
// one per cycle, into a 4-entry queue that can stall it. The back leaves idle
// with a job, runs the bit-serial step divide after reset or a change of sample
// count, and issues one sample per cycle, unless stalled, into a 4-stage pipeline.
// Reset clears the window, the point count and all valid state.
// When out_valid is high and out_ready low the whole back pipeline holds; the
// queue then fills and in_ready drops, with no item lost.
module catmull_rom_path_interpolator #(
	parameter int MAX_SAMPLES = cri_pkg::DEF_MAX_SAMPLES,
	parameter int COORD_BITS = cri_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cri_pkg::COUNT_BITS-1:0] cfg_wdata,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          path_end,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic signed [COORD_BITS-1:0]  sample_x,
	output logic signed [COORD_BITS-1:0]  sample_y,
	output logic                          final_sample,
	output logic                          out_valid,
	input  logic                          out_ready
);
	localparam int NB = cri_pkg::COUNT_BITS;
	localparam int JW = 8 * (COORD_BITS + cri_pkg::COEF_GUARD) + 1;

	logic [NB-1:0] count_q, n_eff;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	logic [JW-1:0] fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= cri_pkg::SAMPLE_COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	assign n_eff = (count_q > NB'(MAX_SAMPLES)) ? NB'(MAX_SAMPLES) : count_q;

	cri_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.point_x(point_x), .point_y(point_y), .path_end(path_end),
		.in_valid(in_valid), .in_ready(in_ready),
		.n_samples(n_eff),
		.job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
	);

	cri_fifo #(.WIDTH(JW), .DEPTH(cri_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fj_valid), .push_ready(fj_ready), .push_data(fj_data),
		.pop_valid(bj_valid), .pop_ready(bj_ready), .pop_data(bj_data)
	);

	cri_back #(.MAX_SAMPLES(MAX_SAMPLES), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.n_samples(n_eff),
		.job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
		.sample_x(sample_x), .sample_y(sample_y), .final_sample(final_sample),
		.out_valid(out_valid), .out_ready(out_ready)
	);
endmodule

// ===== rtl/cri_fifo.sv =====
// Small register queue carrying segment jobs from front to back.
// Uses cri_pkg only through parameters handed down from the top level.
module cri_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_pop_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> $past(rd_q) != rd_q || DEPTH == 1) else $error("read pointer stuck");
	a_push_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> $past(wr_q) != wr_q || DEPTH == 1) else $error("write pointer stuck");
`endif
endmodule

// ===== rtl/cri_front.sv =====
// Front end: accepts control points, keeps the three-point window and
// turns each point into segment jobs (polynomial coefficients). Uses cri_pkg.
module cri_front #(
	parameter int COORD_BITS = cri_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [COORD_BITS-1:0]          point_x,
	input  logic signed [COORD_BITS-1:0]          point_y,
	input  logic                                  path_end,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cri_pkg::COUNT_BITS-1:0]        n_samples,
	output logic                                  job_valid,
	input  logic                                  job_ready,
	output logic [8*(COORD_BITS+cri_pkg::COEF_GUARD):0] job_data
);
	localparam int CW = COORD_BITS + cri_pkg::COEF_GUARD;

	typedef enum logic [1:0] {F_IDLE, F_SEGA, F_SEGB, F_FIN} fstate_t;
	fstate_t state_q;

	logic signed [COORD_BITS-1:0] wx_q [3];
	logic signed [COORD_BITS-1:0] wy_q [3];
	logic [1:0] seen_q;
	logic signed [COORD_BITS-1:0] nx_q, ny_q;
	logic end_q;

	logic need_a, need_b, push;
	logic signed [COORD_BITS-1:0] px [4];
	logic signed [COORD_BITS-1:0] py [4];
	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];

	function automatic logic signed [CW-1:0] ext(input logic signed [COORD_BITS-1:0] v);
		ext = CW'(v);
	endfunction

	assign in_ready = (state_q == F_IDLE);
	assign need_a = (seen_q >= 2'd2) && (n_samples != '0);
	assign need_b = end_q && (seen_q >= 2'd1) && (n_samples != '0);
	assign job_valid = ((state_q == F_SEGA) && need_a) || ((state_q == F_SEGB) && need_b)
		|| (state_q == F_FIN);
	assign push = job_valid && job_ready;

	always_comb begin
		case (state_q)
			F_SEGA: begin
				px[0] = (seen_q == 2'd2) ? wx_q[1] : wx_q[0];
				py[0] = (seen_q == 2'd2) ? wy_q[1] : wy_q[0];
				px[1] = wx_q[1]; py[1] = wy_q[1];
				px[2] = wx_q[2]; py[2] = wy_q[2];
				px[3] = nx_q;    py[3] = ny_q;
			end
			F_SEGB: begin
				px[0] = (seen_q == 2'd1) ? wx_q[2] : wx_q[1];
				py[0] = (seen_q == 2'd1) ? wy_q[2] : wy_q[1];
				px[1] = wx_q[2]; py[1] = wy_q[2];
				px[2] = nx_q;    py[2] = ny_q;
				px[3] = nx_q;    py[3] = ny_q;
			end
			default: begin
				// closing point: all four equal gives a = 2p, b = c = d = 0
				for (int i = 0; i < 4; i++) begin
					px[i] = nx_q;
					py[i] = ny_q;
				end
			end
		endcase
		cx[0] = ext(px[1]) <<< 1;
		cx[1] = ext(px[2]) - ext(px[0]);
		cx[2] = (ext(px[0]) <<< 1) - CW'(5) * ext(px[1]) + (ext(px[2]) <<< 2) - ext(px[3]);
		cx[3] = CW'(3) * ext(px[1]) - ext(px[0]) - CW'(3) * ext(px[2]) + ext(px[3]);
		cy[0] = ext(py[1]) <<< 1;
		cy[1] = ext(py[2]) - ext(py[0]);
		cy[2] = (ext(py[0]) <<< 1) - CW'(5) * ext(py[1]) + (ext(py[2]) <<< 2) - ext(py[3]);
		cy[3] = CW'(3) * ext(py[1]) - ext(py[0]) - CW'(3) * ext(py[2]) + ext(py[3]);
	end

	assign job_data = {state_q == F_FIN, cx[0], cx[1], cx[2], cx[3], cy[0], cy[1], cy[2], cy[3]};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			nx_q <= point_x;
			ny_q <= point_y;
			end_q <= path_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			seen_q <= '0;
			for (int i = 0; i < 3; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_SEGA;
				end
				F_SEGA: begin
					if (!need_a || push) begin
						if (end_q) begin
							state_q <= F_SEGB;
						end else begin
							wx_q[0] <= wx_q[1]; wx_q[1] <= wx_q[2]; wx_q[2] <= nx_q;
							wy_q[0] <= wy_q[1]; wy_q[1] <= wy_q[2]; wy_q[2] <= ny_q;
							if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
							state_q <= F_IDLE;
						end
					end
				end
				F_SEGB: begin
					if (!need_b || push) state_q <= F_FIN;
				end
				F_FIN: begin
					if (push) begin
						for (int i = 0; i < 3; i++) begin
							wx_q[i] <= '0;
							wy_q[i] <= '0;
						end
						seen_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/cri_back.sv =====
// Back end: steps t over each job's samples and evaluates the cubic in a
// four-stage pipeline with saturation. Uses cri_pkg constants.
module cri_back #(
	parameter int MAX_SAMPLES = cri_pkg::DEF_MAX_SAMPLES,
	parameter int COORD_BITS = cri_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [cri_pkg::COUNT_BITS-1:0]        n_samples,
	input  logic                                  job_valid,
	output logic                                  job_ready,
	input  logic [8*(COORD_BITS+cri_pkg::COEF_GUARD):0] job_data,
	output logic signed [COORD_BITS-1:0]          sample_x,
	output logic signed [COORD_BITS-1:0]          sample_y,
	output logic                                  final_sample,
	output logic                                  out_valid,
	input  logic                                  out_ready
);
	localparam int CW = COORD_BITS + cri_pkg::COEF_GUARD;
	localparam int FB = cri_pkg::FRAC_BITS;
	localparam int NB = cri_pkg::COUNT_BITS;
	localparam int SB = $clog2(MAX_SAMPLES + 1);
	localparam int PW = CW + FB + 1;
	localparam int SW = CW + 2;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_RUN} bstate_t;
	bstate_t state_q;

	logic job_fin;
	logic signed [CW-1:0] jc [8];
	always_comb begin
		job_fin = job_data[8*CW];
		for (int i = 0; i < 8; i++) begin
			jc[i] = job_data[(8-i)*CW-1 -: CW];
		end
	end

	// 65536 / n, computed one quotient bit a cycle and kept while n holds
	logic [FB:0] qn_q;
	logic [NB-1:0] rn_q, div_n_q;
	logic div_ok_q;
	logic [NB-1:0] div_cnt_q;
	logic [NB:0] div_trial;

	logic [FB:0] t_q;
	logic [NB-1:0] r_q;
	logic [SB-1:0] s_q;
	logic [NB-1:0] n_job;
	logic [NB:0] r_sum;
	logic issue, last, adv;

	logic v1_s1, v2_s2, v3_s3;
	logic [FB-1:0] t_s1, t2_s1, t_s2, t2_s2, t3_s2;
	logic fin_s1, fin_s2, fin_s3;
	logic signed [CW-1:0] c_s1 [8];
	logic signed [CW-1:0] c_s2 [8];
	logic signed [CW-1:0] c_s3 [8];
	logic [2*FB-1:0] sq, cu;
	logic signed [PW-1:0] prod [6];
	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] s);
		logic signed [SW-2:0] h;
		h = s[SW-1:1];
		if ((&h[SW-2:COORD_BITS-1]) || !(|h[SW-2:COORD_BITS-1])) begin
			sat = h[COORD_BITS-1:0];
		end else begin
			sat = h[SW-2] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

	assign adv = !out_valid || out_ready;
	assign n_job = job_fin ? NB'(1) : n_samples;
	assign issue = (state_q == B_RUN) && adv;
	assign last = (NB'(s_q) == n_job - NB'(1));
	assign job_ready = issue && last;
	assign div_trial = {rn_q, div_cnt_q == NB'(FB)};
	assign r_sum = {1'b0, r_q} + {1'b0, rn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			div_ok_q <= 1'b0;
			div_n_q <= '0;
			div_cnt_q <= '0;
			qn_q <= '0;
			rn_q <= '0;
			t_q <= '0;
			r_q <= '0;
			s_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					t_q <= '0;
					r_q <= '0;
					s_q <= '0;
					if (job_valid) begin
						if (job_fin || (div_ok_q && div_n_q == n_samples)) begin
							state_q <= B_RUN;
						end else begin
							div_cnt_q <= NB'(FB);
							rn_q <= '0;
							qn_q <= '0;
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					if (div_trial >= {1'b0, n_samples}) begin
						rn_q <= NB'(div_trial - {1'b0, n_samples});
						qn_q <= {qn_q[FB-1:0], 1'b1};
					end else begin
						rn_q <= div_trial[NB-1:0];
						qn_q <= {qn_q[FB-1:0], 1'b0};
					end
					if (div_cnt_q == '0) begin
						div_ok_q <= 1'b1;
						div_n_q <= n_samples;
						state_q <= B_RUN;
					end else begin
						div_cnt_q <= div_cnt_q - NB'(1);
					end
				end
				B_RUN: begin
					if (issue) begin
						if (last) begin
							state_q <= B_IDLE;
						end else begin
							s_q <= s_q + SB'(1);
							if (r_sum >= {1'b0, n_samples}) begin
								r_q <= NB'(r_sum - {1'b0, n_samples});
								t_q <= t_q + qn_q + (FB+1)'(1);
							end else begin
								r_q <= r_sum[NB-1:0];
								t_q <= t_q + qn_q;
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign sq = t_q[FB-1:0] * t_q[FB-1:0];
	assign cu = t2_s1 * t_s1;

	always_comb begin
		prod[0] = $signed(c_s2[1]) * $signed({1'b0, t_s2});
		prod[1] = $signed(c_s2[2]) * $signed({1'b0, t2_s2});
		prod[2] = $signed(c_s2[3]) * $signed({1'b0, t3_s2});
		prod[3] = $signed(c_s2[5]) * $signed({1'b0, t_s2});
		prod[4] = $signed(c_s2[6]) * $signed({1'b0, t2_s2});
		prod[5] = $signed(c_s2[7]) * $signed({1'b0, t3_s2});
		sum_x = SW'(c_s3[0]) + SW'(c_s3[1]) + SW'(c_s3[2]) + SW'(c_s3[3]);
		sum_y = SW'(c_s3[4]) + SW'(c_s3[5]) + SW'(c_s3[6]) + SW'(c_s3[7]);
		sat_x = sat(sum_x);
		sat_y = sat(sum_y);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_q[FB-1:0];
			t2_s1 <= sq[2*FB-1:FB];
			fin_s1 <= job_fin;
			c_s1 <= jc;
			t_s2 <= t_s1;
			t2_s2 <= t2_s1;
			t3_s2 <= cu[2*FB-1:FB];
			fin_s2 <= fin_s1;
			c_s2 <= c_s1;
			// products floored to Q36.0 integers by dropping the low fraction bits
			c_s3[0] <= c_s2[0];
			c_s3[1] <= prod[0][CW+FB-1:FB];
			c_s3[2] <= prod[1][CW+FB-1:FB];
			c_s3[3] <= prod[2][CW+FB-1:FB];
			c_s3[4] <= c_s2[4];
			c_s3[5] <= prod[3][CW+FB-1:FB];
			c_s3[6] <= prod[4][CW+FB-1:FB];
			c_s3[7] <= prod[5][CW+FB-1:FB];
			fin_s3 <= fin_s2;
			sample_x <= sat_x;
			sample_y <= sat_y;
			final_sample <= fin_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v1_s1 <= issue;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			out_valid <= v3_s3;
		end
	end

`ifndef SYNTHESIS
	a_run_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RUN |-> job_valid) else $error("sequencer running without a job");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RUN |-> NB'(s_q) < n_job) else $error("sample index past count");
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_ok_q) || (state_q == B_RUN && $past(state_q) == B_DIV)
		|-> (qn_q * div_n_q + rn_q) == (1 << FB) && rn_q < div_n_q)
		else $error("step divider result wrong");
`endif
endmodule

// ===== dv/catmull_rom_path_interpolator_tb.sv =====
// Testbench for the Catmull-Rom path interpolator: drives control points, predicts samples
// with its own spline model, and checks every output sample in order.
// Depends on cri_pkg and the catmull_rom_path_interpolator RTL.
`timescale 1ns / 1ps

module catmull_rom_path_interpolator_tb;
	localparam int CB = cri_pkg::DEF_COORD_BITS;
	localparam int MAXS = cri_pkg::DEF_MAX_SAMPLES;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 fin;
	} sample_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [cri_pkg::COUNT_BITS-1:0] cfg_wdata = '0;
	logic signed [CB-1:0] point_x = '0, point_y = '0;
	logic path_end = 0, in_valid = 0, out_ready = 0;
	logic in_ready, out_valid, final_sample;
	logic signed [CB-1:0] sample_x, sample_y;

	catmull_rom_path_interpolator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.point_x(point_x), .point_y(point_y), .path_end(path_end),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_x(sample_x), .sample_y(sample_y), .final_sample(final_sample),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	always #10 clk = ~clk;

	// spline predictor state
	int unsigned seg_samples = cri_pkg::SAMPLE_COUNT_RESET;
	longint win_x[3], win_y[3];
	int unsigned held_pts;

	point_t pending_pts[$];
	sample_t expected_samples[$];
	int mismatches = 0, unexpected = 0, samples_seen = 0, points_sent = 0;
	int ends_sent = 0;
	longint cycle = 0;
	int in_gap = 0, out_gap = 0;

	// handshake snapshots taken at the rising edge
	logic in_ready_s = 0, out_valid_s = 0;

	function automatic longint spline_eval(longint p0, longint p1, longint p2, longint p3,
			longint t, longint t2, longint t3);
		longint a, b, c, d, sum, mx;
		a = 2 * p1;
		b = p2 - p0;
		c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		d = -p0 + 3 * p1 - 3 * p2 + p3;
		// products fit 64 bits: coefficients under 2^36, t under 2^16
		sum = a + ((b * t) >>> 16) + ((c * t2) >>> 16) + ((d * t3) >>> 16);
		sum = sum >>> 1;
		mx = (64'sd1 <<< (CB - 1)) - 1;
		if (sum > mx) sum = mx;
		if (sum < -mx - 1) sum = -mx - 1;
		return sum;
	endfunction

	function automatic void push_segment(longint x0, longint x1, longint x2, longint x3,
			longint y0, longint y1, longint y2, longint y3);
		longint t, t2, t3;
		int unsigned n;
		sample_t smp;
		n = (seg_samples > MAXS) ? MAXS : seg_samples;
		for (int unsigned s = 0; s < n; s++) begin
			t = (longint'(s) << 16) / n;
			t2 = (t * t) >> 16;
			t3 = (t2 * t) >> 16;
			smp.x = CB'(spline_eval(x0, x1, x2, x3, t, t2, t3));
			smp.y = CB'(spline_eval(y0, y1, y2, y3, t, t2, t3));
			smp.fin = 0;
			expected_samples.insert(expected_samples.size(), smp);
		end
	endfunction

	function automatic void predict_point(point_t p);
		longint nx, ny;
		sample_t smp;
		nx = p.x;
		ny = p.y;
		if (held_pts == 2)
			push_segment(win_x[1], win_x[1], win_x[2], nx, win_y[1], win_y[1], win_y[2], ny);
		else if (held_pts >= 3)
			push_segment(win_x[0], win_x[1], win_x[2], nx, win_y[0], win_y[1], win_y[2], ny);
		if (p.last) begin
			if (held_pts == 1)
				push_segment(win_x[2], win_x[2], nx, nx, win_y[2], win_y[2], ny, ny);
			else if (held_pts >= 2)
				push_segment(win_x[1], win_x[2], nx, nx, win_y[1], win_y[2], ny, ny);
			smp.x = p.x;
			smp.y = p.y;
			smp.fin = 1;
			expected_samples.insert(expected_samples.size(), smp);
			win_x = '{0, 0, 0};
			win_y = '{0, 0, 0};
			held_pts = 0;
		end else begin
			win_x = '{win_x[1], win_x[2], nx};
			win_y = '{win_y[1], win_y[2], ny};
			if (held_pts < 3) held_pts++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CB-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return {1'b0, {(CB-1){1'b1}}};
			1: return {1'b1, {(CB-1){1'b0}}};
			2, 3: return CB'($urandom);
			default: return CB'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready_s) begin
				// accepted at the last rising edge
				if (pending_pts.size() > 0 && in_gap == 0) begin
					{point_x, point_y, path_end} <= pending_pts.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
				in_gap <= pick_gap();
			end else if (!in_valid) begin
				if (in_gap > 0)
					in_gap <= in_gap - 1;
				else if (pending_pts.size() > 0) begin
					{point_x, point_y, path_end} <= pending_pts.pop_front();
					in_valid <= 1;
				end
			end
			if (out_gap > 0) begin
				out_ready <= 0;
				out_gap <= out_gap - 1;
			end else begin
				out_ready <= 1;
				if (out_valid_s && out_ready) out_gap <= pick_gap();
			end
		end
	end

	// monitor: samples on the rising edge
	always @(posedge clk) begin
		sample_t exp_s;
		in_ready_s <= in_valid && in_ready;
		out_valid_s <= out_valid && out_ready;
		cycle <= cycle + 1;
		if (arst_n && in_valid && in_ready) begin
			predict_point('{point_x, point_y, path_end});
			points_sent++;
			if (path_end) ends_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected sample x=%h y=%h fin=%b", sample_x, sample_y,
						final_sample);
			end else begin
				exp_s = expected_samples.pop_front();
				if (exp_s.x !== sample_x || exp_s.y !== sample_y
						|| exp_s.fin !== final_sample) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("mismatch: exp x=%h y=%h fin=%b got x=%h y=%h fin=%b",
							exp_s.x, exp_s.y, exp_s.fin, sample_x, sample_y, final_sample);
				end
			end
		end
		if (cycle > LIMIT) begin
			$display("timeout at cycle %0d", cycle);
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.last = last;
		pending_pts.insert(pending_pts.size(), p);
	endtask

	task automatic add_path(int len);
		for (int i = 0; i < len; i++)
			add_point(rand_coord(), rand_coord(), i == len - 1);
	endtask

	task automatic drain_and_set(logic [cri_pkg::COUNT_BITS-1:0] n);
		while (pending_pts.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 0;
		seg_samples = n;
	endtask

	initial begin
		logic [cri_pkg::COUNT_BITS-1:0] settings[6];
		int budget;
		win_x = '{0, 0, 0};
		win_y = '{0, 0, 0};
		held_pts = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed at the reset count: single point, two points, extremes
		add_point('0, '0, 1);
		add_point({1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 0);
		add_point({1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, 1);
		add_point({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}}, 0);
		add_point({1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}}, 0);
		add_point({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}}, 0);
		add_point('1, '1, 0);
		add_point(32'h0001_0000, 32'hFFFF_0000, 1);
		add_path(3);

		// zero count: only end points come out
		drain_and_set(0);
		add_path(1);
		add_path(4);
		drain_and_set(31);
		add_path(5);

		settings = '{1, 31, 2, 7, 20, 3};
		budget = 144;
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_set(settings[ph]);
			for (int k = 0; k < budget / 6;) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
				add_path(len);
				k += len;
			end
		end
		// a last two-point path: an open point then a closing point
		add_point(rand_coord(), rand_coord(), 0);
		add_point(rand_coord(), rand_coord(), 1);

		while (pending_pts.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d points in %0d paths, checked %0d samples over counts 0..31",
			points_sent, ends_sent, samples_seen);
		if (mismatches == 0 && unexpected == 0 && expected_samples.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
